// ===== hdl/mwn_pkg.sv =====
// Shared types and constants for the multi-waveform NCO.
// No dependencies; every other file in hdl/ imports this package.
package mwn_pkg;

    localparam int OFFSET_W   = 10;
    localparam int WAVE_W     = 2;
    localparam int GAIN_W     = 16;
    localparam int SHAPE_W    = 19;
    localparam int SAMPLE_W   = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // waveform select codes
    localparam logic [WAVE_W-1:0] WAVE_RAMP   = 2'd0;
    localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd1;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd2;
    localparam logic [WAVE_W-1:0] WAVE_TRI    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 1'd1;

    localparam logic [WAVE_W-1:0] WAVE_RESET = WAVE_SINE;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

    // 2*pi in Q15, sine polynomial coefficients in Q16
    localparam logic [17:0] TWO_PI_Q15 = 18'd205887;
    localparam logic [16:0] SIN_A      = 17'd102944;
    localparam logic [15:0] SIN_B      = 16'd42048;
    localparam logic [12:0] SIN_C      = 13'd4640;
    localparam logic [14:0] QUARTER_Q14 = 15'd16384;

    typedef logic signed [SHAPE_W-1:0]  shape_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // per-stage pipeline control
    typedef struct packed {
        logic valid;
        logic wrap;
    } mwn_ctl_t;

endpackage

// ===== hdl/mwn_if.sv =====
// Handshake channel interfaces for the multi-waveform NCO.
// Depends on mwn_pkg for payload widths and types.
interface mwn_req_if
    import mwn_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                advance;
    logic [OFFSET_W-1:0] phase_offset;

    modport source (output valid, output advance, output phase_offset, input ready);
    modport sink   (input valid, input advance, input phase_offset, output ready);
endinterface

interface mwn_rsp_if
    import mwn_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    cycle_start;

    modport source (output valid, output sample, output cycle_start, input ready);
    modport sink   (input valid, input sample, input cycle_start, output ready);
endinterface

interface mwn_cfg_if
    import mwn_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/mwn_phase.sv =====
// Phase accumulator: counter step, wrap detect and offset add (stage 1).
// Depends on mwn_pkg.
module mwn_phase
    import mwn_pkg::*;
#(
    parameter int PHASE_BITS = 10
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  acc,
    input  logic                  advance,
    input  logic [OFFSET_W-1:0]   phase_offset,
    output logic [PHASE_BITS-1:0] p_reg,
    output mwn_ctl_t              ctl_reg
);

    logic [PHASE_BITS-1:0]          count_reg;
    logic [PHASE_BITS-1:0]          count_inc;
    logic [PHASE_BITS-1:0]          count_next;
    logic [PHASE_BITS+OFFSET_W-1:0] off_wide;
    logic [PHASE_BITS-1:0]          off_ph;
    logic                           wrap_now;

    assign count_inc  = count_reg + PHASE_BITS'(1);
    assign count_next = advance ? count_inc : count_reg;
    assign wrap_now   = advance && (count_inc == '0);
    // offset taken modulo 2^PHASE_BITS
    assign off_wide   = {{PHASE_BITS{1'b0}}, phase_offset};
    assign off_ph     = off_wide[PHASE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (acc)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg.valid <= acc;
            ctl_reg.wrap  <= acc && wrap_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= count_next + off_ph;
        end
    end

    a_wrap_to_zero: assert property (@(posedge clk) disable iff (!rst_n)
        acc && advance && (count_reg == '1) |=> (count_reg == '0) && ctl_reg.wrap)
        else $error("phase counter did not wrap to zero with cycle flag");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !acc |=> $stable(count_reg))
        else $error("phase counter moved without an accepted beat");

endmodule

// ===== hdl/mwn_shape.sv =====
// Waveform shape generation: ramp/square/triangle in stage 1, sine polynomial
// over stages 2..5 with one multiply per stage. Depends on mwn_pkg.
module mwn_shape
    import mwn_pkg::*;
#(
    parameter int PHASE_BITS = 10
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [WAVE_W-1:0]     wave,
    input  logic [PHASE_BITS-1:0] p,
    input  mwn_ctl_t              ctl_in,
    output shape_t                shape_reg,
    output mwn_ctl_t              ctl_reg
);

    localparam int RW = PHASE_BITS + 18;

    // stage 1 combinational
    logic [15+PHASE_BITS:0] u_sh;
    logic [15:0]            u;
    logic [14:0]            xq;
    logic [14:0]            x1;
    logic [RW-1:0]          ramp_mul;
    logic [RW-1:0]          ramp_rnd;
    logic [17:0]            ramp_val;
    shape_t                 us;
    shape_t                 tri_val;
    shape_t                 sq_val;
    shape_t                 alt1;
    logic [29:0]            xx;

    // stage 2..5 registers
    mwn_ctl_t    ctl2_reg, ctl3_reg, ctl4_reg;
    logic [14:0] x2_reg, x3_reg, x4_reg;
    logic [14:0] z2_2_reg, z2_3_reg;
    logic [15:0] t2_3_reg;
    logic [16:0] t4_4_reg;
    logic        neg2_reg, neg3_reg, neg4_reg;
    shape_t      alt2_reg, alt3_reg, alt4_reg;

    // stage combinational terms
    logic [27:0] z2c;
    logic [15:0] t2_next;
    logic [30:0] z2t2;
    logic [16:0] t4_next;
    logic [31:0] xt4;
    shape_t      sine_mag;
    shape_t      sine_val;

    // 16-bit angle
    assign u_sh = {16'b0, p} << (16 - PHASE_BITS);
    assign u    = u_sh[15:0];
    assign xq   = {1'b0, u[13:0]};
    assign x1   = u[14] ? (QUARTER_Q14 - xq) : xq;
    assign xx   = 30'(x1) * 30'(x1);

    assign ramp_mul = RW'(p) * RW'(TWO_PI_Q15);
    assign ramp_rnd = ramp_mul + (RW'(1) << (PHASE_BITS - 1));
    assign ramp_val = ramp_rnd[PHASE_BITS+17:PHASE_BITS];

    assign sq_val = p[PHASE_BITS-1] ? SHAPE_W'(32768) : -SHAPE_W'(32768);

    assign us = shape_t'({3'b0, u});
    always_comb
    begin
        if (u < 16'd16384)
        begin
            tri_val = us <<< 1;
        end
        else if (u < 16'd49152)
        begin
            tri_val = (SHAPE_W'(32768) - us) <<< 1;
        end
        else
        begin
            tri_val = (us - SHAPE_W'(65536)) <<< 1;
        end
    end

    always_comb
    begin
        case (wave)
            WAVE_RAMP:   alt1 = shape_t'({1'b0, ramp_val});
            WAVE_SQUARE: alt1 = sq_val;
            WAVE_TRI:    alt1 = tri_val;
            default:     alt1 = '0;
        endcase
    end

    // polynomial z*(A - z^2*(B - z^2*C))
    assign z2c      = 28'(z2_2_reg) * 28'(SIN_C);
    assign t2_next  = SIN_B - 16'(z2c[27:14]);
    assign z2t2     = 31'(z2_3_reg) * 31'(t2_3_reg);
    assign t4_next  = SIN_A - 17'(z2t2[30:14]);
    assign xt4      = 32'(x4_reg) * 32'(t4_4_reg);
    assign sine_mag = shape_t'({2'b0, xt4[31:15]});
    assign sine_val = neg4_reg ? -sine_mag : sine_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl_reg  <= '0;
        end
        else if (en)
        begin
            ctl2_reg <= ctl_in;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl_reg  <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg    <= x1;
            z2_2_reg  <= 15'(xx[29:14]);
            neg2_reg  <= u[15];
            alt2_reg  <= alt1;

            x3_reg    <= x2_reg;
            z2_3_reg  <= z2_2_reg;
            t2_3_reg  <= t2_next;
            neg3_reg  <= neg2_reg;
            alt3_reg  <= alt2_reg;

            x4_reg    <= x3_reg;
            t4_4_reg  <= t4_next;
            neg4_reg  <= neg3_reg;
            alt4_reg  <= alt3_reg;

            shape_reg <= (wave == WAVE_SINE) ? sine_val : alt4_reg;
        end
    end

endmodule

// ===== hdl/mwn_scale.sv =====
// Output stage: gain multiply, round to Q4.15, result register and stall control.
// Depends on mwn_pkg.
module mwn_scale
    import mwn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [GAIN_W-1:0] gain,
    input  shape_t            shape,
    input  mwn_ctl_t          ctl_in,
    input  logic              ready,
    output logic              en,
    output sample_t           sample_reg,
    output mwn_ctl_t          ctl_reg
);

    logic signed [16:0] gain_s;
    logic signed [35:0] prod;
    logic signed [35:0] rnd;

    // whole pipeline moves when the result register is free or being taken
    assign en     = !ctl_reg.valid || ready;
    assign gain_s = signed'({1'b0, gain});
    assign prod   = 36'(gain_s) * 36'(shape);
    // floor((prod + 2^14) / 2^15)
    assign rnd    = prod + 36'sd16384;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_reg <= rnd[34:15];
        end
    end

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(sample_reg) && $stable(ctl_reg))
        else $error("result register changed while stalled");

endmodule

// ===== hdl/multi_waveform_nco.sv =====
// Multi-waveform NCO top level: config registers and pipeline wiring.
// Depends on mwn_pkg, mwn_if, mwn_phase, mwn_shape, mwn_scale.
//
// Accepts one beat per clock while rsp does not stall and returns one
// sample beat for each, in order. A beat passes through the phase register,
// the sine stage registers, the shape register and the result register on
// its way to rsp. The depth is set by the sine polynomial, which spends one
// stage per multiply, followed by the gain multiply in the result register
// stage. The phase counter updates at acceptance, so back-to-back beats with
// advance set see consecutive phases. When rsp stalls the whole pipeline
// holds and req.ready drops in the same cycle. Config writes are always
// taken and should be issued only while no beat is in flight.
module multi_waveform_nco
    import mwn_pkg::*;
#(
    parameter int PHASE_BITS = 10
)(
    input  logic       clk,
    input  logic       rst_n,
    mwn_req_if.sink    req,
    mwn_rsp_if.source  rsp,
    mwn_cfg_if.sink    cfg
);

    logic [WAVE_W-1:0]     waveform_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic                  en;
    logic                  acc;
    logic [PHASE_BITS-1:0] p1;
    mwn_ctl_t              ctl1;
    mwn_ctl_t              ctl5;
    mwn_ctl_t              ctl_out;
    shape_t                shape5;
    sample_t               sample_q;

    assign cfg.ready = 1'b1;
    assign req.ready = en;
    assign acc       = req.valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= WAVE_RESET;
            gain_reg     <= GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_WAVEFORM: waveform_reg <= cfg.data[WAVE_W-1:0];
                REG_GAIN:     gain_reg     <= cfg.data[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    mwn_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .acc          (acc),
        .advance      (req.advance),
        .phase_offset (req.phase_offset),
        .p_reg        (p1),
        .ctl_reg      (ctl1)
    );

    mwn_shape #(
        .PHASE_BITS (PHASE_BITS)
    ) u_shape (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .wave      (waveform_reg),
        .p         (p1),
        .ctl_in    (ctl1),
        .shape_reg (shape5),
        .ctl_reg   (ctl5)
    );

    mwn_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .gain       (gain_reg),
        .shape      (shape5),
        .ctl_in     (ctl5),
        .ready      (rsp.ready),
        .en         (en),
        .sample_reg (sample_q),
        .ctl_reg    (ctl_out)
    );

    assign rsp.valid       = ctl_out.valid;
    assign rsp.sample      = sample_q;
    assign rsp.cycle_start = ctl_out.wrap;

    a_cfg_wave: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && (cfg.index == REG_WAVEFORM)
        |=> waveform_reg == $past(cfg.data[WAVE_W-1:0]))
        else $error("waveform register write lost");

endmodule
